/* design/tcw_pkg.sv */
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared widths, command codes and character codes of the text console writer.
// ---------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int TCW_ROWS = 30;
  localparam int TCW_COLS = 70;

  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CHAR_W  = 8;
  localparam int CMD_W   = 2;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] CODE_BS = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_NL = 8'd10;
  localparam logic [CHAR_W-1:0] MARK    = 8'h5F;

  localparam logic REG_SHELL_MODE = 1'b0;

endpackage

`default_nettype wire

/* design/text_console_writer_top.sv */
// ---------------------------------------------------------------------------
// text_console_writer_top
// Text-mode console writer: character store in one synchronous RAM, cursor
// and scroll offset in registers, one result item per command item.
// ---------------------------------------------------------------------------
// The character store is one RAM of ROWS x 128 cells with one write and one
// read port; rows are kept as a ring, so a scroll moves the top-row offset
// and clears only the freed row. Items go one at a time through a sequencer,
// and the next item is accepted in the idle cycle after the result is
// registered. A put or a shell backspace goes through write, mark write,
// result and idle. A newline, a plain backspace, an out-of-range read or
// unused command 3 goes through execute, result and idle, and an in-range
// read adds a RAM read step before the result. A put or newline that runs
// off the last row adds a scroll step that clears the freed row. Command 2
// and the clearing pass after reset sweep all ROWS*128 cells (3840 at the
// default size), during which cmd_stall is high. A finished result waits in
// the output register while the next item is accepted; if it is still
// waiting when the next result is ready, the sequencer holds until it leaves.
`default_nettype none

module text_console_writer_top #(
  parameter int ROWS = tcw_pkg::TCW_ROWS,
  parameter int COLS = tcw_pkg::TCW_COLS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cmd_valid,
  output      logic                        cmd_stall,
  input  wire logic [tcw_pkg::CMD_W-1:0]   cmd,
  input  wire logic [tcw_pkg::CHAR_W-1:0]  char_code,
  input  wire logic [tcw_pkg::ROW_W-1:0]   read_row,
  input  wire logic [tcw_pkg::COL_W-1:0]   read_col,
  output      logic                        res_valid,
  input  wire logic                        res_stall,
  output      logic [tcw_pkg::CHAR_W-1:0]  cell_char,
  output      logic [tcw_pkg::ROW_W-1:0]   cursor_row,
  output      logic [tcw_pkg::COL_W-1:0]   cursor_col,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tcw_pkg::PADDR_W-1:0] paddr,
  input  wire logic [tcw_pkg::PDATA_W-1:0] pwdata,
  output      logic [tcw_pkg::PDATA_W-1:0] prdata,
  output      logic                        pready
);
  import tcw_pkg::*;

  localparam int RW     = $clog2(ROWS);
  localparam int AW     = RW + COL_W;
  localparam int DEPTH  = ROWS * 128;
  localparam logic [RW-1:0]    ROW_LAST = RW'(ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);
  localparam logic [AW-1:0]    ADDR_LAST = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_MARK,
    S_READ,
    S_RESP
  } state_t;

  state_t              state;
  logic                shell_mode;
  logic [RW-1:0]       cur_row;
  logic [COL_W-1:0]    cur_col;
  logic [RW-1:0]       top_row;
  logic [RW-1:0]       scr_prow;
  logic [COL_W-1:0]    clr_col;
  logic [AW-1:0]       clr_addr;
  logic                mark_pend;
  logic                resp_pend;
  logic [CMD_W-1:0]    op_cmd;
  logic [CHAR_W-1:0]   op_char;
  logic [ROW_W-1:0]    op_row;
  logic [COL_W-1:0]    op_col;
  logic [CHAR_W-1:0]   cell_q;

  logic [CHAR_W-1:0]   mem [DEPTH];
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [CHAR_W-1:0]   mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [CHAR_W-1:0]   mem_rdata;

  logic [RW-1:0]       cur_prow;
  logic [RW-1:0]       rd_prow;
  logic                cmd_accept;
  logic                cfg_write;
  logic                op_special;
  logic                rd_in_range;

  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r, input logic [RW-1:0] t);
    logic [RW:0] sum;
    sum = {1'b0, r} + {1'b0, t};
    if (sum >= (RW+1)'(ROWS)) begin
      sum = sum - (RW+1)'(ROWS);
    end
    return sum[RW-1:0];
  endfunction

  assign cmd_stall  = (state != S_IDLE);
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign prdata     = (paddr[2] == REG_SHELL_MODE) ? PDATA_W'(shell_mode) : '0;

  assign cur_prow    = phys_row(cur_row, top_row);
  assign rd_prow     = phys_row(op_row[RW-1:0], top_row);
  assign op_special  = (op_char == CODE_BS) || (op_char == CODE_NL);
  assign rd_in_range = ({1'b0, op_row} < (ROW_W+1)'(ROWS))
                    && ({1'b0, op_col} < (COL_W+1)'(COLS));
  assign mem_raddr   = {rd_prow, op_col};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {cur_prow, cur_col};
    mem_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      S_EXEC: begin
        mem_we    = (op_cmd == CMD_PUT)
                 && ((op_char != CODE_BS) || shell_mode || (cur_col != '0));
        mem_wdata = op_special ? '0 : op_char;
      end
      S_SCROLL: begin
        mem_we    = 1'b1;
        mem_waddr = {scr_prow, clr_col};
      end
      S_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = MARK;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      shell_mode <= 1'b0;
      cur_row    <= '0;
      cur_col    <= '0;
      top_row    <= '0;
      clr_addr   <= '0;
      resp_pend  <= 1'b0;
      mark_pend  <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (cfg_write && (paddr[2] == REG_SHELL_MODE)) begin
        shell_mode <= pwdata[0];
      end
      if (res_valid && !res_stall && (state != S_RESP)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == ADDR_LAST) begin
            state <= resp_pend ? S_RESP : S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_accept) begin
            op_cmd  <= cmd;
            op_char <= char_code;
            op_row  <= read_row;
            op_col  <= read_col;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          cell_q <= '0;
          case (op_cmd)
            CMD_PUT: begin
              if (op_char == CODE_BS) begin
                if (shell_mode) begin
                  if (cur_col == '0) begin
                    if (cur_row != '0) begin
                      cur_col <= COL_LAST;
                      cur_row <= cur_row - RW'(1);
                    end
                  end else begin
                    cur_col <= cur_col - COL_W'(1);
                  end
                  state <= S_MARK;
                end else begin
                  if (cur_col != '0) begin
                    cur_col <= cur_col - COL_W'(1);
                  end
                  state <= S_RESP;
                end
              end else if ((op_char == CODE_NL) || (cur_col == COL_LAST)) begin
                cur_col   <= '0;
                mark_pend <= (op_char != CODE_NL);
                if (cur_row == ROW_LAST) begin
                  scr_prow <= top_row;
                  top_row  <= (top_row == ROW_LAST) ? '0 : top_row + RW'(1);
                  clr_col  <= '0;
                  state    <= S_SCROLL;
                end else begin
                  cur_row <= cur_row + RW'(1);
                  state   <= (op_char != CODE_NL) ? S_MARK : S_RESP;
                end
              end else begin
                cur_col <= cur_col + COL_W'(1);
                state   <= S_MARK;
              end
            end
            CMD_READ: begin
              state <= rd_in_range ? S_READ : S_RESP;
            end
            CMD_CLEAR: begin
              cur_row   <= '0;
              cur_col   <= '0;
              top_row   <= '0;
              clr_addr  <= '0;
              resp_pend <= 1'b1;
              state     <= S_CLEAR;
            end
            default: begin
              state <= S_RESP;
            end
          endcase
        end
        S_SCROLL: begin
          clr_col <= clr_col + COL_W'(1);
          if (clr_col == COL_LAST) begin
            state <= mark_pend ? S_MARK : S_RESP;
          end
        end
        S_MARK: begin
          state <= S_RESP;
        end
        S_READ: begin
          cell_q <= mem_rdata;
          state  <= S_RESP;
        end
        S_RESP: begin
          if (!res_valid || !res_stall) begin
            res_valid  <= 1'b1;
            cell_char  <= cell_q;
            cursor_row <= ROW_W'(cur_row);
            cursor_col <= cur_col;
            resp_pend  <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    cur_col <= COL_LAST)
    else $error("cursor column beyond last column");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    (cur_row <= ROW_LAST) && (top_row <= ROW_LAST))
    else $error("cursor row or top row beyond last row");

  a_write_cols: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state != S_CLEAR)) |-> (mem_waddr[COL_W-1:0] <= COL_LAST))
    else $error("store written outside visible columns");

  a_clear_home: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> ((cur_row == '0) && (cur_col == '0)))
    else $error("cursor not homed during clear sweep");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    cmd_accept |=> (state == S_EXEC) && !cmd_stall == 1'b0)
    else $error("item accepted without entering execution");

endmodule

`default_nettype wire
